[rtl/frmd_pkg.sv]
// Shared widths, character codes and defaults for the frame rate meter.
package frmd_pkg;

    localparam int FRAMES_DEF = 10;

    localparam int TIME_W  = 32;   // one frame duration, microseconds
    localparam int TOTAL_W = 36;   // running window total
    localparam int FPS_W   = 24;   // frames per second
    localparam int CHAR_W  = 7;    // ASCII display character
    localparam int BIN_W   = 14;   // enough for any rate below 10000
    localparam int BCD_W   = 16;   // four decimal digits

    localparam int US_PER_SEC = 1000000;

    localparam logic [FPS_W-1:0] FPS_SAT = FPS_W'(10000);
    localparam logic [FPS_W-1:0] FPS_1K  = FPS_W'(1000);
    localparam logic [FPS_W-1:0] FPS_100 = FPS_W'(100);

    localparam logic [CHAR_W-1:0] ASCII_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 7'h39;

    localparam int M_DATA_W = 56;  // 52 payload bits padded to bytes

endpackage

[rtl/frmd_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module frmd_div import frmd_pkg::*; #(
    parameter int DVD_W = FPS_W,
    parameter int DVS_W = TOTAL_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVD_W-1:0] q_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W+1:0] diff;
    logic             ge;

    // shift in the next dividend bit, subtract when it fits
    assign trial = {rem_reg, q_reg[DVD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};
    assign ge    = ~diff[DVS_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            q_reg   <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            q_reg   <= {q_reg[DVD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[rtl/frame_rate_meter_decimal_unit.sv]
// Frame rate meter: moving window of frame times, divider, decimal display.
// Processing: the accepted input word passes the divide, the quotient load, binary to BCD
//   and the output load to m_tvalid; a saturated rate skips BCD, a zero total goes straight to the output load.
// One item in flight: s_tready is low until the result is loaded, and it stays low
//   while a finished result waits on m_tready.
// Reset (rst_n, async, active low) clears the window and total to zero.
module frame_rate_meter_decimal_unit import frmd_pkg::*; #(
    parameter int FRAMES = FRAMES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TIME_W-1:0]   s_tdata,   // [31:0] frame_time_us
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    // [23:0] fps_value, [30:24] char_thousands, [37:31] char_hundreds,
    // [44:38] char_tens, [51:45] char_units, [55:52] zero padding
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser    // [0] zero_total
);

    // dividend 1e6 * FRAMES fits the 24-bit rate field only while FRAMES is at most 16
    localparam logic [FPS_W-1:0] DIVIDEND = FPS_W'(US_PER_SEC * FRAMES);
    localparam int BCD_CNT_W = $clog2(BIN_W);
    localparam logic [BCD_CNT_W-1:0] BCD_LAST = BCD_CNT_W'(BIN_W - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_BCD,
        S_OUT
    } state_t;

    state_t                 state_reg;
    logic [TIME_W-1:0]      hist_reg [FRAMES];
    logic [TOTAL_W-1:0]     total_reg;
    logic [FPS_W-1:0]       fps_reg;
    logic                   zero_reg;
    logic                   sat_reg;
    logic [BIN_W-1:0]       bin_reg;
    logic [BCD_W-1:0]       bcd_reg;
    logic [BCD_CNT_W-1:0]   cnt_reg;

    logic                   m_tvalid_reg;
    logic [M_DATA_W-1:0]    m_tdata_reg;
    logic                   m_tuser_reg;

    logic                   accept;
    logic [TOTAL_W-1:0]     total_next;
    logic                   div_start;
    logic                   div_done;
    logic [FPS_W-1:0]       quotient;
    logic [BCD_W-1:0]       bcd_adj;
    logic                   out_free;
    logic                   out_load;

    logic [CHAR_W-1:0]      c_thou, c_hund, c_tens, c_unit;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;

    // drop the oldest duration, add the newest
    assign total_next = total_reg - {{(TOTAL_W-TIME_W){1'b0}}, hist_reg[FRAMES-1]}
                                  + {{(TOTAL_W-TIME_W){1'b0}}, s_tdata};
    assign div_start  = accept && (total_next != '0);

    frmd_div #(
        .DVD_W (FPS_W),
        .DVS_W (TOTAL_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DIVIDEND),
        .divisor  (total_next),
        .done     (div_done),
        .quotient (quotient)
    );

    // add 3 to any BCD digit of 5 or more ahead of the shift
    always_comb
    begin
        for (int i = 0; i < BCD_W / 4; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                              : bcd_reg[4*i +: 4];
        end
    end

    // display characters; blanks lead a short rate, all nines on overflow or zero
    always_comb
    begin
        if (zero_reg || sat_reg)
        begin
            c_thou = ASCII_NINE;
            c_hund = ASCII_NINE;
            c_tens = ASCII_NINE;
            c_unit = ASCII_NINE;
        end
        else
        begin
            c_thou = (fps_reg < FPS_1K)  ? ASCII_SPACE : ASCII_ZERO + {3'b000, bcd_reg[15:12]};
            c_hund = (fps_reg < FPS_100) ? ASCII_SPACE : ASCII_ZERO + {3'b000, bcd_reg[11:8]};
            c_tens = ASCII_ZERO + {3'b000, bcd_reg[7:4]};
            c_unit = ASCII_ZERO + {3'b000, bcd_reg[3:0]};
        end
    end

    assign out_free = ~m_tvalid_reg | m_tready;
    assign out_load = (state_reg == S_OUT) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            total_reg    <= '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                hist_reg[i] <= '0;
            end
            zero_reg     <= 1'b0;
            sat_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            // a new result replaces the one taken at this edge
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {4'b0000, c_unit, c_tens, c_hund, c_thou, fps_reg};
                m_tuser_reg  <= zero_reg;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        for (int i = FRAMES - 1; i >= 1; i--)
                        begin
                            hist_reg[i] <= hist_reg[i-1];
                        end
                        hist_reg[0] <= s_tdata;
                        total_reg   <= total_next;
                        sat_reg     <= 1'b0;
                        if (total_next == '0)
                        begin
                            zero_reg  <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            zero_reg  <= 1'b0;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (quotient >= FPS_SAT)
                        begin
                            sat_reg   <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_BCD;
                        end
                    end
                end
                S_BCD:
                begin
                    if (cnt_reg == BCD_LAST)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                fps_reg <= '0;
                bcd_reg <= '0;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    fps_reg <= quotient;
                    bin_reg <= quotient[BIN_W-1:0];
                    bcd_reg <= '0;
                    cnt_reg <= '0;
                end
            end
            S_BCD:
            begin
                {bcd_reg, bin_reg} <= {bcd_adj[BCD_W-2:0], bin_reg, 1'b0};
                cnt_reg            <= cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
